[sv/rhs_pkg.sv]
// Package for running_height_statistics: sequencer state type and fixed sum width.
// No dependencies.
package rhs_pkg;

  localparam int SUMSQ_BITS = 62;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MEAN,
    ST_DEV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

endpackage

[sv/running_height_statistics.sv]
// Running height statistics: count, Welford mean, squared-deviation sum, min, max.
// Uses rhs_pkg for the sequencer state type and the sum width.
// Each item passes the one-bit-per-cycle restoring divider, the mean update, the deviation
// set-up, the one-bit-per-cycle shift-add multiplier and the sum update before out_valid.
// The block takes no new item until it has finished the last one; in_ready
// is high only while idle, and a finished result waits in the output register while the next
// item is accepted. Reset (synchronous, rst_n low): count, mean and sum cleared, min to
// largest positive, max to most negative, no result pending.
module running_height_statistics #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   in_height,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COUNT_BITS-1:0]           out_sample_count,
  output logic signed [SAMPLE_BITS-1:0]   out_mean_height,
  output logic [rhs_pkg::SUMSQ_BITS-1:0]  out_sum_sq_dev,
  output logic signed [SAMPLE_BITS-1:0]   out_lowest_height,
  output logic signed [SAMPLE_BITS-1:0]   out_highest_height
);

  localparam int D   = SAMPLE_BITS + 1;
  localparam int PB  = 2 * D;
  localparam int SB  = rhs_pkg::SUMSQ_BITS;
  localparam int PW  = ((PB > SB) ? PB : SB) + 1;
  localparam int CW  = $clog2(D);
  localparam logic [CW-1:0] BIT_LAST = CW'(D - 1);

  rhs_pkg::state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0]          count_r, count_nxt;
  logic signed [SAMPLE_BITS-1:0]  mean_r, mean_nxt;
  logic [SB-1:0]                  sumsq_r, sumsq_nxt;
  logic signed [SAMPLE_BITS-1:0]  min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0]  max_r, max_nxt;

  logic signed [SAMPLE_BITS-1:0]  z_r, z_nxt;
  logic                           neg_r, neg_nxt;
  logic [D-1:0]                   dmag_r, dmag_nxt;
  logic [D-1:0]                   dq_r, dq_nxt;
  logic [COUNT_BITS:0]            rem_r, rem_nxt;
  logic [CW-1:0]                  bit_r, bit_nxt;
  logic [PB-1:0]                  acc_r, acc_nxt;
  logic [PB-1:0]                  mcand_r, mcand_nxt;
  logic [D-1:0]                   mplier_r, mplier_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [COUNT_BITS-1:0]          o_count_r;
  logic signed [SAMPLE_BITS-1:0]  o_mean_r, o_min_r, o_max_r;
  logic [SB-1:0]                  o_sumsq_r;

  logic                           accept, load_out;
  logic signed [D-1:0]            diff;
  logic [D-1:0]                   diff_mag;
  logic [COUNT_BITS:0]            rem_sh;
  logic                           qbit;
  logic signed [D:0]              mean_sum;
  logic [PW-1:0]                  sum_w;

  assign in_ready = (state_r == rhs_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == rhs_pkg::ST_OUT) && (!out_valid_r || out_ready);

  // shared subtractor: sample minus mean, used at accept and again after the mean update
  always_comb begin
    diff     = D'(accept ? in_height : z_r) - D'(mean_r);
    diff_mag = diff[D-1] ? D'(-diff) : D'(diff);
  end

  always_comb begin
    rem_sh   = {rem_r[COUNT_BITS-1:0], dq_r[D-1]};
    qbit     = (rem_sh >= {1'b0, count_r});
    mean_sum = (D+1)'(mean_r) + (neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r}));
    sum_w    = PW'(sumsq_r) + PW'(acc_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rhs_pkg::ST_IDLE: if (accept) state_nxt = rhs_pkg::ST_DIV;
      rhs_pkg::ST_DIV:  if (bit_r == '0) state_nxt = rhs_pkg::ST_MEAN;
      rhs_pkg::ST_MEAN: state_nxt = rhs_pkg::ST_DEV;
      rhs_pkg::ST_DEV:  state_nxt = rhs_pkg::ST_MUL;
      rhs_pkg::ST_MUL:  if (bit_r == '0) state_nxt = rhs_pkg::ST_ACC;
      rhs_pkg::ST_ACC:  state_nxt = rhs_pkg::ST_OUT;
      rhs_pkg::ST_OUT:  if (load_out) state_nxt = rhs_pkg::ST_IDLE;
      default:          state_nxt = rhs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    mean_nxt   = mean_r;
    sumsq_nxt  = sumsq_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    z_nxt      = z_r;
    neg_nxt    = neg_r;
    dmag_nxt   = dmag_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    bit_nxt    = bit_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    case (state_r)
      rhs_pkg::ST_IDLE: begin
        if (accept) begin
          z_nxt     = in_height;
          count_nxt = (count_r == '1) ? count_r : count_r + 1'b1;
          if (in_height < min_r) min_nxt = in_height;
          if (in_height > max_r) max_nxt = in_height;
        end
      end
      rhs_pkg::ST_DIV: begin
        rem_nxt = qbit ? rem_sh - {1'b0, count_r} : rem_sh;
        dq_nxt  = {dq_r[D-2:0], qbit};
        bit_nxt = bit_r - 1'b1;
      end
      rhs_pkg::ST_MEAN: begin
        mean_nxt = mean_sum[SAMPLE_BITS-1:0];
      end
      rhs_pkg::ST_DEV: begin
        mcand_nxt  = PB'(diff_mag);
        mplier_nxt = dmag_r;
        acc_nxt    = '0;
        bit_nxt    = BIT_LAST;
      end
      rhs_pkg::ST_MUL: begin
        if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt  = {mcand_r[PB-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[D-1:1]};
        bit_nxt    = bit_r - 1'b1;
      end
      rhs_pkg::ST_ACC: begin
        sumsq_nxt = (sum_w[PW-1:SB] != '0) ? '1 : sum_w[SB-1:0];
      end
      default: ;
    endcase
    // divider set-up happens in the accept cycle, from the incoming sample
    if (accept) begin
      neg_nxt  = diff[D-1];
      dmag_nxt = diff_mag;
      dq_nxt   = diff_mag;
      rem_nxt  = '0;
      bit_nxt  = BIT_LAST;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhs_pkg::ST_IDLE;
      count_r     <= '0;
      mean_r      <= '0;
      sumsq_r     <= '0;
      min_r       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_r       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
      sumsq_r     <= sumsq_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r      <= z_nxt;
    neg_r    <= neg_nxt;
    dmag_r   <= dmag_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    bit_r    <= bit_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    if (load_out) begin
      o_count_r <= count_r;
      o_mean_r  <= mean_r;
      o_sumsq_r <= sumsq_r;
      o_min_r   <= min_r;
      o_max_r   <= max_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_count   = o_count_r;
  assign out_mean_height    = o_mean_r;
  assign out_sum_sq_dev     = o_sumsq_r;
  assign out_lowest_height  = o_min_r;
  assign out_highest_height = o_max_r;

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= $past(count_r))
    else $error("sample count went down");

  a_sumsq_mono: assert property (@(posedge clk) disable iff (!rst_n)
    sumsq_r >= $past(sumsq_r))
    else $error("squared deviation sum went down");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (min_r <= max_r))
    else $error("minimum above maximum");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rhs_pkg::ST_DIV) |-> (rem_r < {1'b0, count_r}))
    else $error("divider remainder not below divisor");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(o_sumsq_r) && $stable(o_mean_r))
    else $error("pending result overwritten");

endmodule

[dv/running_height_statistics_tb.sv]
// Testbench for running_height_statistics: drives height samples over valid/ready and
// checks every result against a local predictor of count, mean, squared-deviation sum,
// lowest and highest sample. Depends on rhs_pkg and the running_height_statistics RTL.
module running_height_statistics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SAMPLE_W    = 24;
  localparam int     COUNT_W     = 16;
  localparam int     SUM_W       = rhs_pkg::SUMSQ_BITS;
  localparam longint H_MAX       = 64'sd8388607;
  localparam longint H_MIN       = -64'sd8388608;
  localparam longint CNT_SAT     = (64'sd1 <<< COUNT_W) - 1;
  localparam longint unsigned SUM_SAT = (64'd1 << SUM_W) - 1;
  localparam int     DRAIN_CYCLES = 2 * (SAMPLE_W + 1) + 5 + 20;

  typedef struct packed {
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] mean;
    logic [SUM_W-1:0]           sumsq;
    logic signed [SAMPLE_W-1:0] lowest;
    logic signed [SAMPLE_W-1:0] highest;
  } stats_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  in_height;
  logic                        out_valid;
  logic                        out_ready;
  logic [COUNT_W-1:0]          out_sample_count;
  logic signed [SAMPLE_W-1:0]  out_mean_height;
  logic [SUM_W-1:0]            out_sum_sq_dev;
  logic signed [SAMPLE_W-1:0]  out_lowest_height;
  logic signed [SAMPLE_W-1:0]  out_highest_height;

  running_height_statistics #(
    .COUNT_BITS  (COUNT_W),
    .SAMPLE_BITS (SAMPLE_W)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_height          (in_height),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_count   (out_sample_count),
    .out_mean_height    (out_mean_height),
    .out_sum_sq_dev     (out_sum_sq_dev),
    .out_lowest_height  (out_lowest_height),
    .out_highest_height (out_highest_height)
  );

  // predictor state
  longint          run_count;
  longint          run_mean;
  longint unsigned run_sumsq;
  longint          run_lo;
  longint          run_hi;

  stats_t pending_stats[$];
  int     mismatches;
  int     items_sent;
  int     results_seen;
  bit     tx_idle_en;
  bit     rx_idle_en;
  int     rx_stall_left;
  stats_t got_stats;
  stats_t want_stats;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("running_height_statistics: mismatch");
    $finish;
  end

  function automatic stats_t predict_stats(input logic signed [SAMPLE_W-1:0] z);
    longint          zl;
    longint          delta;
    longint          delta2;
    longint unsigned prod;
    stats_t          s;
    zl = z;
    if (run_count < CNT_SAT) run_count++;
    delta    = zl - run_mean;
    run_mean = run_mean + delta / run_count;
    delta2   = zl - run_mean;
    prod = longint'(delta < 0 ? -delta : delta) * longint'(delta2 < 0 ? -delta2 : delta2);
    if (prod > SUM_SAT - run_sumsq) run_sumsq = SUM_SAT;
    else run_sumsq = run_sumsq + prod;
    if (zl < run_lo) run_lo = zl;
    if (zl > run_hi) run_hi = zl;
    s.count   = run_count[COUNT_W-1:0];
    s.mean    = run_mean[SAMPLE_W-1:0];
    s.sumsq   = run_sumsq[SUM_W-1:0];
    s.lowest  = run_lo[SAMPLE_W-1:0];
    s.highest = run_hi[SAMPLE_W-1:0];
    return s;
  endfunction

  task automatic send_height(input logic signed [SAMPLE_W-1:0] h);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    in_height = h;
    do @(posedge clk); while (!in_ready);
    pending_stats.push_back(predict_stats(h));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_height();
    longint v;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: v = longint'($urandom_range(0, 24'hffffff)) + H_MIN;
      8, 9, 10, 11, 12, 13:    v = run_mean + longint'($urandom_range(0, 8191)) - 4096;
      14, 15:                  v = ($urandom_range(0, 1) != 0) ? H_MAX : H_MIN;
      default:                 v = longint'($urandom_range(0, 511)) - 256;
    endcase
    if (v > H_MAX) v = H_MAX;
    if (v < H_MIN) v = H_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  // result side: random stall bursts
  always @(negedge clk) begin
    if (!rst_n || !rx_idle_en) begin
      out_ready = 1'b1;
      rx_stall_left = 0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready = 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(1, 9) - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_stats.count   = out_sample_count;
      got_stats.mean    = out_mean_height;
      got_stats.sumsq   = out_sum_sq_dev;
      got_stats.lowest  = out_lowest_height;
      got_stats.highest = out_highest_height;
      results_seen++;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: count %0d mean %0d sumsq %0d lo %0d hi %0d",
                   got_stats.count, got_stats.mean, got_stats.sumsq,
                   got_stats.lowest, got_stats.highest);
      end else begin
        want_stats = pending_stats.pop_front();
        if (got_stats.count !== want_stats.count || got_stats.mean !== want_stats.mean ||
            got_stats.sumsq !== want_stats.sumsq || got_stats.lowest !== want_stats.lowest ||
            got_stats.highest !== want_stats.highest) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d exp: count %0d mean %0d sumsq %0d lo %0d hi %0d",
                     results_seen, want_stats.count, want_stats.mean, want_stats.sumsq,
                     want_stats.lowest, want_stats.highest);
            $display("result %0d got: count %0d mean %0d sumsq %0d lo %0d hi %0d",
                     results_seen, got_stats.count, got_stats.mean, got_stats.sumsq,
                     got_stats.lowest, got_stats.highest);
          end
        end
      end
    end
  end

  task automatic test_first_sample();
    send_height(24'sh12_3456);
  endtask

  task automatic test_extreme_heights();
    send_height(H_MIN[SAMPLE_W-1:0]);
    send_height(H_MAX[SAMPLE_W-1:0]);
    send_height('0);
    send_height(-24'sd1);
    send_height(24'sd1);
    repeat (6) begin
      send_height(H_MAX[SAMPLE_W-1:0]);
      send_height(H_MIN[SAMPLE_W-1:0]);
    end
    send_height(H_MIN[SAMPLE_W-1:0]);
    send_height(H_MIN[SAMPLE_W-1:0]);
    send_height(H_MAX[SAMPLE_W-1:0]);
    send_height(H_MAX[SAMPLE_W-1:0]);
    send_height(24'sh55_5555);
    send_height(24'shaa_aaaa);
  endtask

  // hold off until the block has delivered everything, then resume
  task automatic test_idle_drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait_results_drained();
    repeat (5) @(negedge clk);
    send_height(pick_height());
  endtask

  task automatic test_random_heights(input int n);
    repeat (n) send_height(pick_height());
  endtask

  task automatic test_back_to_back(input int n);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (n) send_height(pick_height());
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_height  = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    run_count = 0;
    run_mean  = 0;
    run_sumsq = 0;
    run_lo    = H_MAX;
    run_hi    = H_MIN;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_first_sample();
    test_extreme_heights();
    test_idle_drain();
    test_random_heights(600);
    test_idle_drain();
    test_random_heights(350);
    test_back_to_back(380);

    @(negedge clk);
    in_valid = 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d results checked; count reached %0d of max %0d,",
             items_sent, results_seen, run_count, CNT_SAT);
    $display("heights spanned %0d..%0d, final squared-deviation sum %0d",
             run_lo, run_hi, run_sumsq);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("running_height_statistics: match");
    end else begin
      $display("running_height_statistics: mismatch");
    end
    $finish;
  end

endmodule
